@@ rtl/fipd_pkg.sv @@
// Shared types, constants and helpers for the flux interval PLL decoder.
`timescale 1ns / 1ps

package fipd_pkg;

   // Fixed point and field widths
   localparam int FRAC_BITS = 8;
   localparam int TICK_W    = 16;
   localparam int REG_W     = 18;
   localparam int CSR_IDX_W = 2;

   // Register reset values, 1/256 tick units
   localparam logic [REG_W-1:0] NOMINAL_RESET = 18'd73728;
   localparam logic [REG_W-1:0] MIN_RESET     = 18'd66355;
   localparam logic [REG_W-1:0] MAX_RESET     = 18'd81101;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX     = 2'd2;

   // Interval code bytes
   localparam logic [7:0] ESC_BYTE        = 8'd255;
   localparam logic [7:0] ESC_SHORT_LIMIT = 8'd250;
   localparam logic [8:0] ESC_SHORT_BASE  = 9'd250;

   // Loop filter divisors: phase gain and base of the period gain
   localparam int PHASE_DIV  = 10;
   localparam int PERIOD_DIV = 100;

   typedef struct packed {
      logic [7:0] flux_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic [1:0]        cell_count;
      logic [TICK_W-1:0] interval_ticks;
   } rsp_data_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic diff;
      logic count;
      logic err;
      logic load;
      logic step;
      logic update;
      logic publish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic produce;
      logic out_free;
   } sts_type;

   // Width of the signed phase and error arithmetic
   function automatic int acc_width(input int frac);
      int xw;
      xw = TICK_W + frac;
      return ((xw > 20) ? xw : 20) + 3;
   endfunction

endpackage

@@ rtl/fipd_div.sv @@
// Divider by a constant base times a factor of one to three, by reciprocal multiplication.
`timescale 1ns / 1ps

module fipd_div #(
   parameter int W    = 27,
   parameter int BASE = 10
) (
   input  logic         clock,
   input  logic         step,
   input  logic [1:0]   factor,
   input  logic [W-1:0] dividend,
   output logic [W-1:0] quotient
);

   // Divisors, shifts and rounded-up reciprocals, exact for any W-bit dividend
   localparam int D1 = BASE;
   localparam int D2 = 2 * BASE;
   localparam int D3 = 3 * BASE;
   localparam int K1 = W + $clog2(D1);
   localparam int K2 = W + $clog2(D2);
   localparam int K3 = W + $clog2(D3);
   localparam logic [W:0] M1 = (W + 1)'(((64'd1 << K1) + 64'(D1 - 1)) / 64'(D1));
   localparam logic [W:0] M2 = (W + 1)'(((64'd1 << K2) + 64'(D2 - 1)) / 64'(D2));
   localparam logic [W:0] M3 = (W + 1)'(((64'd1 << K3) + 64'(D3 - 1)) / 64'(D3));

   logic [W:0]   recip;
   logic [2*W:0] product;
   logic [W-1:0] quo_ff, quo_in;

   // Multiply by the reciprocal and drop the scaling bits
   always_comb begin
      case (factor)
         2'd2:    recip = M2;
         2'd3:    recip = M3;
         default: recip = M1;
      endcase
      product = {{(W + 1){1'b0}}, dividend} * {{W{1'b0}}, recip};
      case (factor)
         2'd2:    quo_in = W'(product >> K2);
         2'd3:    quo_in = W'(product >> K3);
         default: quo_in = W'(product >> K1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (step) begin
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

@@ rtl/fipd_ctrl.sv @@
// Sequencing state machine for the flux interval PLL decoder.
`timescale 1ns / 1ps

module fipd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fipd_pkg::sts_type sts,
   output fipd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE, DIFF, COUNT, ERR, LOAD, DIVIDE, UPDATE, PUBLISH
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   // Decode commands from the state
   always_comb begin
      cmd         = '0;
      cmd.accept  = req_valid && !stall_ff;
      cmd.diff    = (state_ff == DIFF);
      cmd.count   = (state_ff == COUNT);
      cmd.err     = (state_ff == ERR);
      cmd.load    = (state_ff == LOAD);
      cmd.step    = (state_ff == DIVIDE);
      cmd.update  = (state_ff == UPDATE);
      cmd.publish = (state_ff == PUBLISH) && sts.out_free;
   end

   assign req_stall = stall_ff;

   // Advance through the PLL step; hold in PUBLISH until the output slot frees
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         stall_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (cmd.accept && sts.produce) begin
                  state_ff <= DIFF;
                  stall_ff <= 1'b1;
               end
            end
            DIFF:   state_ff <= COUNT;
            COUNT:  state_ff <= ERR;
            ERR:    state_ff <= LOAD;
            LOAD:   state_ff <= DIVIDE;
            DIVIDE: state_ff <= UPDATE;
            UPDATE: state_ff <= PUBLISH;
            PUBLISH: begin
               if (sts.out_free) begin
                  state_ff <= IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ rtl/fipd_dp.sv @@
// Datapath: interval decode, PLL arithmetic, registers and output slot.
`timescale 1ns / 1ps

module fipd_dp #(
   parameter int FRAC_BITS = fipd_pkg::FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fipd_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fipd_pkg::rsp_data_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fipd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fipd_pkg::REG_W-1:0]         csr_data,
   input  fipd_pkg::cmd_type                  cmd,
   output fipd_pkg::sts_type                  sts
);

   localparam int TW = fipd_pkg::TICK_W;
   localparam int RW = fipd_pkg::REG_W;
   localparam int XW = TW + FRAC_BITS;
   localparam int AW = fipd_pkg::acc_width(FRAC_BITS);

   typedef enum logic [1:0] {ESC_NONE, ESC_ONE, ESC_TWO, ESC_LOW} esc_type;

   esc_type                escape_ff, escape_in;
   logic [7:0]             low_ff, low_in;
   logic [TW-1:0]          ticks_ff, ticks_in;
   logic                   have;
   logic                   last_ff;
   logic [RW-1:0]          nominal_ff, min_ff, max_ff, period_ff;
   logic signed [AW-1:0]   phase_ff, d_ff, e_ff, np_ff;
   logic [1:0]             n_ff, n_in;
   logic                   neg_ff;
   logic [AW-1:0]          mag_ff;
   logic                   rsp_valid_ff;
   fipd_pkg::rsp_data_type rsp_ff;

   logic [7:0]             byte_in;
   logic signed [AW-1:0]   x_ext;
   logic [RW-1:0]          pd;
   logic [AW:0]            pd_ext, three_pd, five_pd, twice_d;
   logic                   d_pos;
   logic [RW+1:0]          np_prod;
   logic [AW-1:0]          mag;
   logic [AW-1:0]          q_phase, q_period;
   logic signed [AW-1:0]   period_s, min_s, max_s, np_lo, np_cl;
   logic                   csr_we;

   assign byte_in = req_data.flux_byte;

   // Unpack the escape code for the byte on the request port
   always_comb begin
      escape_in = escape_ff;
      low_in    = low_ff;
      ticks_in  = ticks_ff;
      have      = 1'b0;
      case (escape_ff)
         ESC_NONE: begin
            if (byte_in == fipd_pkg::ESC_BYTE) begin
               escape_in = ESC_ONE;
            end else begin
               ticks_in = TW'(byte_in);
               have     = 1'b1;
            end
         end
         ESC_ONE: begin
            escape_in = ESC_NONE;
            if (byte_in < fipd_pkg::ESC_SHORT_LIMIT) begin
               ticks_in = TW'(fipd_pkg::ESC_SHORT_BASE + {1'b0, byte_in});
               have     = 1'b1;
            end else if (byte_in == fipd_pkg::ESC_BYTE) begin
               escape_in = ESC_TWO;
            end else begin
               ticks_in = TW'(byte_in);
               have     = 1'b1;
            end
         end
         ESC_TWO: begin
            low_in    = byte_in;
            escape_in = ESC_LOW;
         end
         default: begin
            ticks_in  = {byte_in, low_ff};
            have      = 1'b1;
            escape_in = ESC_NONE;
         end
      endcase
   end

   assign sts.produce  = have && (ticks_in != '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // Interval as fixed point, and period multiples for the cell count
   always_comb begin
      x_ext    = $signed({{(AW - XW){1'b0}}, ticks_ff, {FRAC_BITS{1'b0}}});
      pd       = (period_ff == '0) ? RW'(1) : period_ff;
      pd_ext   = {{(AW + 1 - RW){1'b0}}, pd};
      three_pd = (pd_ext << 1) + pd_ext;
      five_pd  = (pd_ext << 2) + pd_ext;
      twice_d  = {d_ff, 1'b0};
      d_pos    = !d_ff[AW-1] && (d_ff != '0);
      if (!d_pos) begin
         n_in = 2'd1;
      end else if (twice_d >= five_pd) begin
         n_in = 2'd3;
      end else if (twice_d >= three_pd) begin
         n_in = 2'd2;
      end else begin
         n_in = 2'd1;
      end
      np_prod = {{RW{1'b0}}, n_ff} * {2'b00, period_ff};
      mag     = e_ff[AW-1] ? AW'(-e_ff) : AW'(e_ff);
   end

   // Loop filter dividers: phase by ten, period by a hundred per cell
   fipd_div #(.W(AW), .BASE(fipd_pkg::PHASE_DIV)) u_div_phase (
      .clock    (clock),
      .step     (cmd.step),
      .factor   (2'd1),
      .dividend (mag_ff),
      .quotient (q_phase)
   );

   fipd_div #(.W(AW), .BASE(fipd_pkg::PERIOD_DIV)) u_div_period (
      .clock    (clock),
      .step     (cmd.step),
      .factor   (n_ff),
      .dividend (mag_ff),
      .quotient (q_period)
   );

   // Clamp the new period, lower limit first
   always_comb begin
      period_s = $signed({{(AW - RW){1'b0}}, period_ff});
      min_s    = $signed({{(AW - RW){1'b0}}, min_ff});
      max_s    = $signed({{(AW - RW){1'b0}}, max_ff});
      np_lo    = (np_ff < min_s) ? min_s : np_ff;
      np_cl    = (np_lo > max_s) ? max_s : np_lo;
   end

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= ESC_NONE;
         low_ff       <= '0;
         phase_ff     <= '0;
         period_ff    <= fipd_pkg::NOMINAL_RESET;
         nominal_ff   <= fipd_pkg::NOMINAL_RESET;
         min_ff       <= fipd_pkg::MIN_RESET;
         max_ff       <= fipd_pkg::MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Take the byte; restart the track at once if it ends here silently
         if (cmd.accept) begin
            escape_ff <= escape_in;
            low_ff    <= low_in;
            ticks_ff  <= ticks_in;
            last_ff   <= req_data.last_byte;
            if (req_data.last_byte && !sts.produce) begin
               escape_ff <= ESC_NONE;
               low_ff    <= '0;
               phase_ff  <= '0;
               period_ff <= nominal_ff;
            end
         end
         if (cmd.diff) begin
            d_ff <= x_ext - phase_ff;
         end
         if (cmd.count) begin
            n_ff <= n_in;
         end
         if (cmd.err) begin
            e_ff <= d_ff - $signed({{(AW - RW - 2){1'b0}}, np_prod});
         end
         // Split the error into sign and magnitude for the dividers
         if (cmd.load) begin
            neg_ff <= e_ff[AW-1];
            mag_ff <= mag;
         end
         // Apply the error sign to both quotients
         if (cmd.update) begin
            phase_ff <= neg_ff ? -$signed(q_phase) : $signed(q_phase);
            np_ff    <= period_s + (neg_ff ? -$signed(q_period) : $signed(q_period));
         end
         // Release the result and commit the period
         if (cmd.publish) begin
            period_ff                     <= np_cl[RW-1:0];
            rsp_ff.cell_count             <= n_ff;
            rsp_ff.interval_ticks         <= ticks_ff;
            rsp_valid_ff                  <= 1'b1;
            if (last_ff) begin
               escape_ff <= ESC_NONE;
               low_ff    <= '0;
               phase_ff  <= '0;
               period_ff <= nominal_ff;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // Register writes; a nominal write also loads the tracked period
         if (csr_we) begin
            case (csr_index)
               fipd_pkg::CSR_NOMINAL: begin
                  nominal_ff <= csr_data;
                  period_ff  <= csr_data;
               end
               fipd_pkg::CSR_MIN: min_ff <= csr_data;
               fipd_pkg::CSR_MAX: max_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result only appears after a publish
   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result raised without publish");

   // A waiting result always carries a real interval and cell count
   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.cell_count != 2'd0) && (rsp_ff.interval_ticks != '0))
      else $error("result with zero cells or zero interval");

   // A loop-committed period lies inside clamps that do not cross
   a_period_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.publish && !last_ff && !csr_we && (min_ff <= max_ff)
      |=> (period_ff >= min_ff) && (period_ff <= max_ff))
      else $error("tracked period outside clamps");

endmodule

@@ rtl/flux_interval_pll_decoder.sv @@
// Top level of the flux interval decoder with data separator PLL.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data: flux_byte, last_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_data: cell_count, interval_ticks
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A byte that gives no interval (escape prefix, zero interval) is taken without raising req_stall.
// A byte that gives an interval raises req_stall while it passes through the steps
// difference, cell count, error, magnitude, reciprocal divide, update and publish.
// Its result is registered on rsp when the publish step completes.
// Reset is synchronous and restores the registers to their defaults.
// Publish holds, with req_stall high, while an older result waits under rsp_stall.
`timescale 1ns / 1ps

module flux_interval_pll_decoder #(
   parameter int FRAC_BITS = fipd_pkg::FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fipd_pkg::req_data_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fipd_pkg::rsp_data_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fipd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fipd_pkg::REG_W-1:0]      csr_data
);

   fipd_pkg::cmd_type cmd;
   fipd_pkg::sts_type sts;

   // Sequencer
   fipd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Decode and PLL arithmetic
   fipd_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ bench/fipd_interval_checker.sv @@
// Checker for the flux interval decoder: watches all three channels, predicts and compares.
`timescale 1ns / 1ps

module fipd_interval_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  fipd_pkg::req_data_type         req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  fipd_pkg::rsp_data_type         rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [fipd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fipd_pkg::REG_W-1:0]     csr_data,
   output int                             fail_count,
   output int                             pending
);

   // Escape decoder stages
   localparam logic [1:0] ESC_NONE      = 2'd0;
   localparam logic [1:0] ESC_AFTER_ONE = 2'd1;
   localparam logic [1:0] ESC_AFTER_TWO = 2'd2;
   localparam logic [1:0] ESC_HAVE_LOW  = 2'd3;

   // Keep the log short when the block is badly broken
   localparam int PRINT_LIMIT = 100;

   // Shadow copy of the configuration registers
   logic [fipd_pkg::REG_W-1:0] nominal_reg;
   logic [fipd_pkg::REG_W-1:0] min_reg;
   logic [fipd_pkg::REG_W-1:0] max_reg;

   // Shadow copy of the decoder and loop state
   logic [1:0]                 esc_stage;
   logic [7:0]                 lo_byte;
   longint                     phase_acc;
   logic [fipd_pkg::REG_W-1:0] period_reg;

   // Cell counts and intervals still owed by the block, oldest first
   fipd_pkg::rsp_data_type expected_cells[$];

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void restart_track();
      esc_stage  = ESC_NONE;
      lo_byte    = 8'd0;
      phase_acc  = 0;
      period_reg = nominal_reg;
   endfunction

   // Round the interval to whole cells and pull phase and period towards it
   function automatic void lock_to_interval(input logic [fipd_pkg::TICK_W-1:0] ticks);
      longint                 x;
      longint                 p;
      longint                 pd;
      longint                 d;
      longint                 n;
      longint                 e;
      longint                 np;
      fipd_pkg::rsp_data_type owed;
      x  = longint'(ticks) << fipd_pkg::FRAC_BITS;
      p  = longint'(period_reg);
      pd = (p > 0) ? p : 1;
      d  = x - phase_acc;
      n  = 1;
      if (d > 0) begin
         n = (2 * d + pd) / (2 * pd);
         if (n < 1) n = 1;
         if (n > 3) n = 3;
      end
      e         = x - (phase_acc + n * p);
      phase_acc = e / longint'(fipd_pkg::PHASE_DIV);
      np        = p + e / (longint'(fipd_pkg::PERIOD_DIV) * n);
      // Floor first, then ceiling: crossed limits end at the ceiling
      if (np < longint'(min_reg)) np = longint'(min_reg);
      if (np > longint'(max_reg)) np = longint'(max_reg);
      period_reg          = np[fipd_pkg::REG_W-1:0];
      owed.cell_count     = n[1:0];
      owed.interval_ticks = ticks;
      expected_cells.push_back(owed);
      pending++;
   endfunction

   // Unpack one byte of the interval code
   function automatic void track_flux_byte(input fipd_pkg::req_data_type item);
      logic [fipd_pkg::TICK_W-1:0] ticks;
      logic                        have;
      ticks = '0;
      have  = 1'b0;
      case (esc_stage)
         ESC_NONE: begin
            if (item.flux_byte == fipd_pkg::ESC_BYTE) begin
               esc_stage = ESC_AFTER_ONE;
            end else begin
               ticks = {8'd0, item.flux_byte};
               have  = 1'b1;
            end
         end
         ESC_AFTER_ONE: begin
            if (item.flux_byte < fipd_pkg::ESC_SHORT_LIMIT) begin
               ticks     = {7'd0, fipd_pkg::ESC_SHORT_BASE} + {8'd0, item.flux_byte};
               have      = 1'b1;
               esc_stage = ESC_NONE;
            end else if (item.flux_byte == fipd_pkg::ESC_BYTE) begin
               esc_stage = ESC_AFTER_TWO;
            end else begin
               // drop the escape, the byte stands as a plain interval
               ticks     = {8'd0, item.flux_byte};
               have      = 1'b1;
               esc_stage = ESC_NONE;
            end
         end
         ESC_AFTER_TWO: begin
            lo_byte   = item.flux_byte;
            esc_stage = ESC_HAVE_LOW;
         end
         default: begin
            ticks     = {item.flux_byte, lo_byte};
            have      = 1'b1;
            esc_stage = ESC_NONE;
         end
      endcase
      if (have && ticks != '0)
         lock_to_interval(ticks);
      if (item.last_byte)
         restart_track();
   endfunction

   // Sample every channel at the rising edge
   always @(posedge clock) begin
      fipd_pkg::rsp_data_type want;
      if (reset) begin
         nominal_reg = fipd_pkg::NOMINAL_RESET;
         min_reg     = fipd_pkg::MIN_RESET;
         max_reg     = fipd_pkg::MAX_RESET;
         restart_track();
         expected_cells.delete();
         pending    = 0;
         fail_count = 0;
      end else begin
         // register writes; a new nominal period also reloads the tracked one
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fipd_pkg::CSR_NOMINAL: begin
                  nominal_reg = csr_data;
                  period_reg  = csr_data;
               end
               fipd_pkg::CSR_MIN: min_reg = csr_data;
               fipd_pkg::CSR_MAX: max_reg = csr_data;
               default: ;
            endcase
         end

         // compare each result transaction with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("unexpected result cells=%0d ticks=%0d",
                                         rsp_data.cell_count, rsp_data.interval_ticks));
            end else begin
               want = expected_cells.pop_front();
               pending--;
               if (rsp_data.cell_count !== want.cell_count)
                  report_mismatch($sformatf("cell_count %0d, expected %0d (ticks %0d)",
                                            rsp_data.cell_count, want.cell_count,
                                            want.interval_ticks));
               if (rsp_data.interval_ticks !== want.interval_ticks)
                  report_mismatch($sformatf("interval_ticks %0d, expected %0d",
                                            rsp_data.interval_ticks, want.interval_ticks));
            end
         end

         // predict from each accepted byte transaction
         if (req_valid && !req_stall)
            track_flux_byte(req_data);
      end
   end

endmodule

@@ bench/flux_interval_pll_decoder_tb.sv @@
// Testbench top for the flux interval decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module flux_interval_pll_decoder_tb;

   localparam int  RANDOM_PHASES  = 8;
   localparam int  BYTES_PER_PHASE = 110;
   // Time for an interval to pass through the block, with a wide margin on top
   localparam int  DRAIN_CYCLES   = 60;
   localparam int  LIMIT_CYCLES   = 600000;
   localparam int  REG_TOP        = 262143;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   fipd_pkg::req_data_type         req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   fipd_pkg::rsp_data_type         rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [fipd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fipd_pkg::REG_W-1:0]     csr_data;

   int fail_count;
   int pending;
   int cycle_count;
   int send_idle_pct;
   int stall_pct;

   flux_interval_pll_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fipd_interval_checker check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one byte transaction and hold it until taken
   task automatic send_byte(input logic [7:0] flux, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.flux_byte  <= flux;
      req_data.last_byte  <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [fipd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fipd_pkg::REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Drain every owed result, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic track_end();
      return $urandom_range(99) < 3;
   endfunction

   // Mostly well-formed interval codes with random content, some stray bytes
   task automatic run_random_phase(input int n_bytes);
      int          sent;
      int          pick;
      logic [7:0]  hi;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_byte(8'($urandom_range(254)), track_end());
            sent += 1;
         end else if (pick < 55) begin
            send_byte(fipd_pkg::ESC_BYTE, track_end());
            send_byte(8'($urandom_range(249)), track_end());
            sent += 2;
         end else if (pick < 62) begin
            send_byte(fipd_pkg::ESC_BYTE, track_end());
            send_byte(8'($urandom_range(254, 250)), track_end());
            sent += 2;
         end else if (pick < 90) begin
            // keep most long intervals within a few cells
            hi = ($urandom_range(99) < 70) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
            send_byte(fipd_pkg::ESC_BYTE, track_end());
            send_byte(fipd_pkg::ESC_BYTE, track_end());
            send_byte(8'($urandom_range(255)), track_end());
            send_byte(hi, track_end());
            sent += 4;
         end else begin
            send_byte(8'($urandom_range(255)), track_end());
            sent += 1;
         end
      end
   endtask

   initial begin
      logic [fipd_pkg::REG_W-1:0] nom_set [RANDOM_PHASES];
      logic [fipd_pkg::REG_W-1:0] min_set [RANDOM_PHASES];
      logic [fipd_pkg::REG_W-1:0] max_set [RANDOM_PHASES];
      int                         nom_val;
      int                         max_val;

      // MFM, FM, short cells, extremes, zero period, widest cell, crossed limits
      nom_set = '{18'd73728, 18'd147456, 18'd25600, 18'd256,
                  18'd0,     18'd262143, 18'd73728, 18'd0};
      min_set = '{18'd66355, 18'd132710, 18'd23040, 18'd256,
                  18'd0,     18'd256,    18'd90000, 18'd0};
      max_set = '{18'd81101, 18'd162202, 18'd28160, 18'd262143,
                  18'd0,     18'd262143, 18'd60000, 18'd0};

      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed codes on the reset configuration, no idling
      send_byte(8'd1, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd254, 1'b0);
      // short escapes at both ends of their range
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'd249, 1'b0);
      // escape dropped by a byte from 250 up
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'd250, 1'b0);
      // zero long interval
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b0);
      // two cells, then the longest interval
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // track ends with an escape still open, twice, then on a plain byte
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(fipd_pkg::ESC_BYTE, 1'b0);
      send_byte(8'd7, 1'b1);
      send_byte(fipd_pkg::ESC_BYTE, 1'b1);
      send_byte(8'd100, 1'b1);
      settle();

      // Random phases, each with its own configuration and one of four idling mixes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1) begin
            nom_val = $urandom_range(REG_TOP, 256);
            max_val = nom_val * 11 / 10;
            nom_set[ph] = fipd_pkg::REG_W'(nom_val);
            min_set[ph] = fipd_pkg::REG_W'(nom_val * 9 / 10);
            max_set[ph] = fipd_pkg::REG_W'((max_val > REG_TOP) ? REG_TOP : max_val);
         end
         write_csr(fipd_pkg::CSR_NOMINAL, nom_set[ph]);
         write_csr(fipd_pkg::CSR_MIN, min_set[ph]);
         write_csr(fipd_pkg::CSR_MAX, max_set[ph]);
         csr_valid <= 1'b0;

         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase

         run_random_phase(BYTES_PER_PHASE);
         settle();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fipd_pkg.sv
rtl/fipd_div.sv
rtl/fipd_ctrl.sv
rtl/fipd_dp.sv
rtl/flux_interval_pll_decoder.sv
bench/fipd_interval_checker.sv
bench/flux_interval_pll_decoder_tb.sv
